// ----- src/smv_pkg.sv -----
// shared constants, codes and types of the sparse matrix-vector multiply core
`default_nettype none

package smv_pkg;

    // sizes of the vector store and the row range
    localparam int VECTOR_LENGTH = 1024;
    localparam int MAX_ROWS      = 1024;
    localparam int VEC_AW        = $clog2(VECTOR_LENGTH);

    // field widths
    localparam int CMD_W  = 2;
    localparam int ROW_W  = 10;
    localparam int COL_W  = 10;
    localparam int DATA_W = 32;
    localparam int ACC_W  = 64;
    localparam int FRAC_W = 16;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENTRY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EMPTY = 2'd2;

    // operation codes after classification
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_MAC   = 2'd1;
    localparam logic [1:0] OP_EMPTY = 2'd2;

    // saturation limits of the q16.16 result
    localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // one classified operation in the queue
    typedef struct packed {
        logic [1:0]              op;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [DATA_W-1:0] value;
        logic                    eor;
        logic                    col_ok;
    } t_op;

    // queue status seen by the back end
    typedef struct packed {
        logic valid;
    } t_q_hs;

endpackage

`default_nettype wire

// ----- src/smv_if.sv -----
// valid/ready channel interfaces for the input items and the row results
`default_nettype none

interface smv_item_if;
    logic                             valid;
    logic                             ready;
    logic [smv_pkg::CMD_W-1:0]        cmd;
    logic [smv_pkg::ROW_W-1:0]        row_index;
    logic [smv_pkg::COL_W-1:0]        col_index;
    logic signed [smv_pkg::DATA_W-1:0] entry_value;
    logic                             end_of_row;

    modport source (output valid, cmd, row_index, col_index, entry_value, end_of_row,
                    input ready);
    modport sink   (input valid, cmd, row_index, col_index, entry_value, end_of_row,
                    output ready);
endinterface

interface smv_result_if;
    logic                             valid;
    logic                             ready;
    logic [smv_pkg::ROW_W-1:0]        out_row;
    logic signed [smv_pkg::DATA_W-1:0] row_result;
    logic                             overflow;

    modport source (output valid, out_row, row_result, overflow, input ready);
    modport sink   (input valid, out_row, row_result, overflow, output ready);
endinterface

`default_nettype wire

// ----- src/sparse_matrix_vector_multiply_core.sv -----
// A row's result passes the queue, stages 1-3 and the output register after its closing item.
// One item per cycle unless the output stalls; the multiply-accumulate loop takes one entry a cycle.
// A stalled result output holds the back pipeline; the 4-entry queue absorbs input meanwhile.
// Reset: synchronous active low; clears queue, pipeline valids and accumulator.
// The vector store is not cleared; the user must ensure elements are read only after being written.
// top level of the sparse matrix-vector multiply core
`default_nettype none

module sparse_matrix_vector_multiply_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    smv_item_if.sink     i_item,
    smv_result_if.source o_result
);
    import smv_pkg::*;

    t_op    op;
    t_q_hs  q_hs;
    logic   op_valid;
    logic   op_pop;

    // front: classify and queue
    smv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .o_op       (op),
        .o_op_valid (op_valid),
        .i_op_pop   (op_pop)
    );

    assign q_hs.valid = op_valid;

    // back: multiply-accumulate and narrowing
    smv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (op),
        .i_q      (q_hs),
        .o_op_pop (op_pop),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ----- src/smv_front.sv -----
// front end: accepts items, classifies them and queues the ones that act
`default_nettype none

module smv_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    smv_item_if.sink           i_item,
    output smv_pkg::t_op       o_op,
    output logic               o_op_valid,
    input  wire logic          i_op_pop
);
    import smv_pkg::*;

    t_op               r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    t_op               n_op;
    logic              n_keep;
    logic              row_ok;
    logic              push;

    // classify the incoming item
    always_comb begin
        row_ok       = 32'(i_item.row_index) < MAX_ROWS;
        n_op.row     = i_item.row_index;
        n_op.col     = i_item.col_index;
        n_op.value   = i_item.entry_value;
        n_op.eor     = i_item.end_of_row;
        n_op.col_ok  = 32'(i_item.col_index) < VECTOR_LENGTH;
        unique case (i_item.cmd)
            CMD_LOAD: begin
                n_op.op = OP_LOAD;
                n_keep  = n_op.col_ok;
            end
            CMD_ENTRY: begin
                n_op.op = OP_MAC;
                n_keep  = row_ok;
            end
            CMD_EMPTY: begin
                n_op.op = OP_EMPTY;
                n_keep  = row_ok;
            end
            default: begin
                n_op.op = OP_LOAD;
                n_keep  = 1'b0;
            end
        endcase
    end

    // queue control
    assign i_item.ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push         = i_item.valid && i_item.ready && n_keep;
    assign o_op_valid   = (r_count != '0);
    assign o_op         = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_op_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !i_op_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_op_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= n_op;
        end
    end

endmodule

`default_nettype wire

// ----- src/smv_back.sv -----
// back end: vector store, multiply, saturating accumulate and q16.16 narrowing
`default_nettype none

module smv_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  smv_pkg::t_op       i_op,
    input  smv_pkg::t_q_hs     i_q,
    output logic               o_op_pop,
    smv_result_if.source       o_result
);
    import smv_pkg::*;

    logic [DATA_W-1:0]        r_vec_mem [VECTOR_LENGTH];
    logic [DATA_W-1:0]        r_rd_data;
    logic [VEC_AW-1:0]        addr;
    logic                     en;
    logic                     pop;

    logic                     r_s1_valid;
    logic [1:0]               r_s1_op;
    logic [ROW_W-1:0]         r_s1_row;
    logic signed [DATA_W-1:0] r_s1_value;
    logic                     r_s1_eor;
    logic                     r_s1_col_ok;

    logic                     r_s2_valid;
    logic [1:0]               r_s2_op;
    logic [ROW_W-1:0]         r_s2_row;
    logic                     r_s2_eor;
    logic signed [ACC_W-1:0]  r_s2_prod;
    logic signed [DATA_W-1:0] n_x;

    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_acc_sat;
    logic [ACC_W-1:0]         n_sum;
    logic                     n_ovf;
    logic [ACC_W-1:0]         n_sat_sum;

    logic                     r_s3_valid;
    logic [ROW_W-1:0]         r_s3_row;
    logic [ACC_W-1:0]         r_fin;
    logic                     r_fin_sat;

    logic [ACC_W-FRAC_W:0]    n_shift;
    logic                     n_nsat;
    logic [DATA_W-1:0]        n_res;

    logic                     r_out_valid;
    logic [ROW_W-1:0]         r_out_row;
    logic [DATA_W-1:0]        r_out_res;
    logic                     r_out_ovf;

    // the whole back pipeline moves when the output register can take a result
    assign en       = !r_out_valid || o_result.ready;
    assign pop      = en && i_q.valid;
    assign o_op_pop = pop;
    assign addr     = i_op.col[VEC_AW-1:0];

    // vector store: write on load, registered read for entries
    always_ff @(posedge i_clk) begin
        if (pop && i_op.op == OP_LOAD) begin
            r_vec_mem[addr] <= i_op.value;
        end
        if (en) begin
            r_rd_data <= r_vec_mem[addr];
        end
    end

    // stage 1: operation waits for the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= pop && (i_op.op != OP_LOAD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_op     <= i_op.op;
            r_s1_row    <= i_op.row;
            r_s1_value  <= i_op.value;
            r_s1_eor    <= i_op.eor;
            r_s1_col_ok <= i_op.col_ok;
        end
    end

    // stage 2: exact q32.32 product
    assign n_x = r_s1_col_ok ? $signed(r_rd_data) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_op   <= r_s1_op;
            r_s2_row  <= r_s1_row;
            r_s2_eor  <= r_s1_eor;
            r_s2_prod <= ACC_W'(r_s1_value) * ACC_W'(n_x);
        end
    end

    // stage 3: saturating accumulate, row close
    always_comb begin
        n_sum = r_acc + r_s2_prod;
        n_ovf = (r_acc[ACC_W-1] == r_s2_prod[ACC_W-1]) &&
                (n_sum[ACC_W-1] != r_acc[ACC_W-1]);
        if (n_ovf) begin
            n_sat_sum = r_acc[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                       : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            n_sat_sum = n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_acc_sat  <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= 1'b0;
            if (r_s2_valid) begin
                if (r_s2_op == OP_EMPTY || r_s2_eor) begin
                    r_acc      <= '0;
                    r_acc_sat  <= 1'b0;
                    r_s3_valid <= 1'b1;
                end else begin
                    r_acc     <= n_sat_sum;
                    r_acc_sat <= r_acc_sat || n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_row  <= r_s2_row;
            r_fin     <= (r_s2_op == OP_EMPTY) ? '0 : n_sat_sum;
            r_fin_sat <= (r_s2_op != OP_EMPTY) && (r_acc_sat || n_ovf);
        end
    end

    // stage 4: shift right by 16 rounding half up, saturate to q16.16
    always_comb begin
        n_shift = {r_fin[ACC_W-1], r_fin[ACC_W-1:FRAC_W]}
                + (ACC_W-FRAC_W+1)'(r_fin[FRAC_W-1]);
        n_nsat  = !((&n_shift[ACC_W-FRAC_W:DATA_W-1]) ||
                    !(|n_shift[ACC_W-FRAC_W:DATA_W-1]));
        if (n_nsat) begin
            n_res = n_shift[ACC_W-FRAC_W] ? Q_MIN : Q_MAX;
        end else begin
            n_res = n_shift[DATA_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_row <= r_s3_row;
            r_out_res <= n_res;
            r_out_ovf <= r_fin_sat || n_nsat;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.out_row    = r_out_row;
    assign o_result.row_result = $signed(r_out_res);
    assign o_result.overflow   = r_out_ovf;

endmodule

`default_nettype wire

// ----- src/smv_checker.sv -----
// port-level assertions on the result channel, bound to the top level
`default_nettype none

module smv_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic [smv_pkg::ROW_W-1:0]         i_out_row,
    input wire logic [smv_pkg::DATA_W-1:0]        i_row_result,
    input wire logic                              i_overflow
);

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_row) && $stable(i_row_result) &&
            $stable(i_overflow))
        else $error("result changed while stalled");

    // a presented result carries known fields
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !$isunknown({i_out_row, i_row_result, i_overflow}))
        else $error("unknown bits on a valid result");

    // no result appears right after reset is sampled low
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid ##1 !i_out_valid)
        else $error("result shortly after reset");

endmodule

bind sparse_matrix_vector_multiply_core smv_checker u_smv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_row    (o_result.out_row),
    .i_row_result (o_result.row_result),
    .i_overflow   (o_result.overflow)
);

`default_nettype wire

// ----- sim/tb.sv -----
// testbench of the sparse matrix-vector multiply core with a built-in row sum predictor
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smv_pkg::*;

    // command value that the core ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int     CYCLE_LIMIT     = 400000;
    localparam int     ITEMS_PER_PHASE = 280;
    localparam int     DRAIN_CYCLES    = 20;
    localparam int     MAX_REPORTS     = 10;
    localparam longint ACC_HI          = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_LO          = 64'sh8000_0000_0000_0000;
    localparam longint RES_HI          = longint'($signed(Q_MAX));
    localparam longint RES_LO          = longint'($signed(Q_MIN));

    // one input item as queued for the driver
    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
        logic                     eor;
        bit                       hold;
    } t_item;

    // one finished row as it should leave the core
    typedef struct {
        logic [ROW_W-1:0]         row;
        logic signed [DATA_W-1:0] sum;
        logic                     ovf;
    } t_row_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    smv_item_if   item_if ();
    smv_result_if result_if ();

    sparse_matrix_vector_multiply_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    // clock
    always #5ns i_clk = ~i_clk;

    t_item       items_to_send [$];
    t_row_result due_results [$];
    t_item       sent_item;

    // predicted state of the core
    logic signed [DATA_W-1:0] vec_copy [VECTOR_LENGTH];
    longint                   row_acc = 0;
    bit                       row_sat = 1'b0;

    // stimulus bookkeeping: reads only hit vector elements already written
    bit col_written [VECTOR_LENGTH];
    int written_cols [$];
    bit hold_next;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_cnt = 0;
    int cycle_cnt = 0;

    // row sum prediction for one accepted item
    task automatic predict_dot_product(input t_item it);
        longint      prod;
        longint      total;
        longint      shifted;
        bit          narrow_sat;
        t_row_result res;
        case (it.cmd)
            CMD_LOAD: begin
                if (int'(it.col) < VECTOR_LENGTH) vec_copy[it.col] = it.value;
            end
            CMD_EMPTY: begin
                if (int'(it.row) < MAX_ROWS) begin
                    row_acc = 0;
                    row_sat = 1'b0;
                    res.row = it.row;
                    res.sum = '0;
                    res.ovf = 1'b0;
                    due_results = {due_results, res};
                end
            end
            CMD_ENTRY: begin
                if (int'(it.row) < MAX_ROWS) begin
                    prod = 0;
                    if (int'(it.col) < VECTOR_LENGTH)
                        prod = longint'(it.value) * longint'(vec_copy[it.col]);
                    // saturating 64-bit accumulate
                    total = row_acc + prod;
                    if (row_acc[63] == prod[63] && total[63] != row_acc[63]) begin
                        row_sat = 1'b1;
                        total = row_acc[63] ? ACC_LO : ACC_HI;
                    end
                    row_acc = total;
                    if (it.eor) begin
                        // q32.32 to q16.16, round half up, saturate
                        shifted = row_acc >>> FRAC_W;
                        if (row_acc[FRAC_W-1]) shifted = shifted + 1;
                        narrow_sat = 1'b0;
                        if (shifted > RES_HI) begin
                            narrow_sat = 1'b1;
                            res.sum = Q_MAX;
                        end else if (shifted < RES_LO) begin
                            narrow_sat = 1'b1;
                            res.sum = Q_MIN;
                        end else begin
                            res.sum = shifted[DATA_W-1:0];
                        end
                        res.row = it.row;
                        res.ovf = row_sat || narrow_sat;
                        due_results = {due_results, res};
                        row_acc = 0;
                        row_sat = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col,
                             input logic signed [DATA_W-1:0] value, input logic eor);
        t_item it;
        it.cmd   = cmd;
        it.row   = row;
        it.col   = col;
        it.value = value;
        it.eor   = eor;
        it.hold  = hold_next;
        hold_next = 1'b0;
        if (cmd == CMD_LOAD && !col_written[col]) begin
            col_written[col] = 1'b1;
            written_cols = {written_cols, int'(col)};
        end
        items_to_send = {items_to_send, it};
    endtask

    // mostly small q16.16 values, some extremes, some full range
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: begin
                case ($urandom_range(4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 32'h0000_0001;
                    3: return 32'hFFFF_FFFF;
                    default: return '0;
                endcase
            end
            default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    // well-formed rows with random content, plus loads, aborted rows and noise
    task automatic add_random_items(input int n_items);
        int               sent;
        int               len;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(19))
                0, 1: begin
                    push_item(CMD_LOAD, ROW_W'($urandom),
                              COL_W'($urandom_range(VECTOR_LENGTH - 1)),
                              pick_value(), 1'($urandom));
                    sent++;
                end
                2: push_item(CMD_UNUSED, ROW_W'($urandom), COL_W'($urandom), $urandom,
                             1'($urandom));
                3: begin
                    push_item(CMD_EMPTY, ROW_W'($urandom), COL_W'($urandom), $urandom,
                              1'($urandom));
                    sent++;
                end
                default: begin
                    len = $urandom_range(1, 6);
                    row = ROW_W'($urandom);
                    for (int k = 0; k < len; k++) begin
                        col = COL_W'(written_cols[$urandom_range(written_cols.size() - 1)]);
                        if (k == len - 1 && $urandom_range(9) == 0)
                            push_item(CMD_EMPTY, row, COL_W'($urandom), $urandom,
                                      1'($urandom));
                        else
                            push_item(CMD_ENTRY, row, col, pick_value(), k == len - 1);
                        sent++;
                    end
                end
            endcase
        end
    endtask

    // driver: keeps valid up until the item is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                predict_dot_product(sent_item);
            end
            if (!item_if.valid || item_if.ready) begin
                if (items_to_send.size() != 0
                        && !(items_to_send[0].hold && due_results.size() != 0)
                        && $urandom_range(99) >= send_idle_pct) begin
                    sent_item = items_to_send.pop_front();
                    item_if.valid       <= 1'b1;
                    item_if.cmd         <= sent_item.cmd;
                    item_if.row_index   <= sent_item.row;
                    item_if.col_index   <= sent_item.col;
                    item_if.entry_value <= sent_item.value;
                    item_if.end_of_row  <= sent_item.eor;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each row result with the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_row_result want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (due_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("unexpected result: row %0d sum %h overflow %0b",
                                 result_if.out_row, result_if.row_result, result_if.overflow);
                end else begin
                    want = due_results.pop_front();
                    if (result_if.out_row !== want.row || result_if.row_result !== want.sum
                            || result_if.overflow !== want.ovf) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display("mismatch: got %0d %h %0b, want %0d %h %0b",
                                     result_if.out_row, result_if.row_result, result_if.overflow,
                                     want.row, want.sum, want.ovf);
                    end
                end
            end
            result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int phase;
        i_rst_n               = 1'b0;
        item_if.valid         = 1'b0;
        item_if.cmd           = CMD_LOAD;
        item_if.row_index     = '0;
        item_if.col_index     = '0;
        item_if.entry_value   = '0;
        item_if.end_of_row    = 1'b0;
        result_if.ready       = 1'b0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        hold_next             = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // vector elements at the extremes, 1.0, -1.0, 0.5 and the top column
        push_item(CMD_LOAD, '0, 10'd0, 32'h8000_0000, 1'b0);
        push_item(CMD_LOAD, '0, 10'd1, 32'h7FFF_FFFF, 1'b0);
        push_item(CMD_LOAD, '0, 10'd2, 32'h0001_0000, 1'b0);
        push_item(CMD_LOAD, '0, 10'd3, 32'hFFFF_0000, 1'b0);
        push_item(CMD_LOAD, '0, 10'd4, 32'h0000_8000, 1'b0);
        push_item(CMD_LOAD, 10'h3FF, 10'h3FF, 32'h1234_5678, 1'b1);
        // plain single-entry row
        push_item(CMD_ENTRY, 10'd0, 10'd2, 32'h0001_0000, 1'b1);
        // accumulator overflow upward, then downward
        push_item(CMD_ENTRY, 10'h3FF, 10'd0, 32'h8000_0000, 1'b0);
        push_item(CMD_ENTRY, 10'h3FF, 10'd0, 32'h8000_0000, 1'b1);
        for (int k = 0; k < 3; k++)
            push_item(CMD_ENTRY, 10'd9, 10'd0, 32'h7FFF_FFFF, k == 2);
        // narrowing saturates without accumulator overflow
        push_item(CMD_ENTRY, 10'd10, 10'd1, 32'h7FFF_FFFF, 1'b1);
        // half-up rounding on both signs
        push_item(CMD_ENTRY, 10'd5, 10'd4, 32'h0000_0001, 1'b1);
        push_item(CMD_ENTRY, 10'd6, 10'd4, 32'hFFFF_FFFF, 1'b1);
        // empty row drops a partial sum, ignored command inside the row
        push_item(CMD_ENTRY, 10'd7, 10'd2, 32'h0005_0000, 1'b0);
        push_item(CMD_UNUSED, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 1'b1);
        push_item(CMD_EMPTY, 10'd7, 10'd0, '0, 1'b0);
        push_item(CMD_ENTRY, 10'd8, 10'd3, 32'h0002_0000, 1'b1);
        // top row and top column
        push_item(CMD_ENTRY, 10'h3FF, 10'h3FF, 32'h8000_0000, 1'b1);

        // random phases with different idle patterns
        for (phase = 0; phase < 4; phase++) begin
            while (items_to_send.size() != 0) @(negedge i_clk);
            case (phase)
                1: begin
                    send_idle_pct  = 81;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 81;
                end
                3: begin
                    send_idle_pct  = 20;
                    recv_stall_pct = 20;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            // the first item of later phases waits for the core to drain
            hold_next = (phase != 0);
            add_random_items(ITEMS_PER_PHASE);
        end

        // drain
        while (items_to_send.size() != 0 || item_if.valid) @(negedge i_clk);
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_cnt == 0 && due_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/smv_pkg.sv
src/smv_if.sv
src/smv_front.sv
src/smv_back.sv
src/sparse_matrix_vector_multiply_core.sv
src/smv_checker.sv
sim/tb.sv
